// ----- sv/sstf_pkg.sv -----
// sstf_pkg: widths, payload structs, register indexes and the saturation helper
// for the segment surface tension force block
// depends on nothing; imported by the top level and the testbench
package sstf_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NORM_FRAC     = 30;
  localparam int OUT_W         = 32;
  localparam int SIG_W         = 32;

  // difference of two coordinates and its magnitude
  localparam int DIFF_W = COORD_BITS + 1;
  // squares, cross products and their sums
  localparam int SQ_W   = 2 * DIFF_W;
  // floor square root of a 2*LEN_W bit radicand
  localparam int LEN_W  = DIFF_W + 1;
  // first divider round: quotient bits and numerator width
  localparam int Q1_W   = LEN_W + 2;
  localparam int N1_W   = LEN_W + Q1_W;
  localparam int LANES1 = 6;
  // second divider round
  localparam int PROD_W = Q1_W + SIG_W;
  localparam int Q2_W   = 63;
  localparam int N2_W   = LEN_W + Q2_W;
  // normal component and split damping product
  localparam int NRM_W   = NORM_FRAC + 1;
  localparam int PLO_W   = 32;
  localparam int PHI_W   = Q2_W - PLO_W;
  localparam int SUM_W   = PHI_W + NRM_W + PLO_W + 1;
  localparam int SAT_W   = SUM_W - NORM_FRAC;

  localparam logic [Q2_W-1:0] P_CLAMP = {1'b1, {(Q2_W-1){1'b0}}};

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLICIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT = 2'd2;

  // divider lane order in the first round
  localparam int LN_TX = 0;
  localparam int LN_TY = 1;
  localparam int LN_NX = 2;
  localparam int LN_NY = 3;
  localparam int LN_SM = 4;
  localparam int LN_ST = 5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_a_x;
    logic signed [COORD_BITS-1:0] pos_a_y;
    logic signed [COORD_BITS-1:0] pos_b_x;
    logic signed [COORD_BITS-1:0] pos_b_y;
    logic signed [COORD_BITS-1:0] vel_a_x;
    logic signed [COORD_BITS-1:0] vel_a_y;
    logic signed [COORD_BITS-1:0] vel_b_x;
    logic signed [COORD_BITS-1:0] vel_b_y;
  } seg_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tension_x;
    logic signed [OUT_W-1:0] tension_y;
    logic signed [OUT_W-1:0] damping_x;
    logic signed [OUT_W-1:0] damping_y;
    logic [OUT_W-1:0]        energy_term;
    logic [OUT_W-1:0]        stiffness;
    logic                    degenerate;
    logic                    saturated;
  } seg_out_t;

  // carried alongside the square root
  typedef struct packed {
    logic [DIFF_W-1:0] adx;
    logic [DIFF_W-1:0] ady;
    logic [SQ_W-1:0]   wm;
    logic              wneg;
    logic              dxneg;
    logic              dyneg;
    logic              dypos;
  } sq_side_t;

  // carried alongside the first divider round
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             dxneg;
    logic             dyneg;
    logic             dypos;
    logic             wneg;
    logic             ovs;
    logic             esat;
    logic [OUT_W-1:0] energy;
  } side1_t;

  // carried alongside the second round and the damping stages
  typedef struct packed {
    logic [DIFF_W-1:0] tx;
    logic [DIFF_W-1:0] ty;
    logic [NRM_W-1:0]  nx;
    logic [NRM_W-1:0]  ny;
    logic [Q1_W-1:0]   st;
    logic              zero;
    logic              dxneg;
    logic              dyneg;
    logic              dypos;
    logic              wneg;
    logic              ovs;
    logic              ovp;
    logic              esat;
    logic [OUT_W-1:0]  energy;
  } side2_t;

  // sign and magnitude to signed OUT_W bits, clip flag on top
  function automatic logic [OUT_W:0] sat_s32(input logic neg, input logic [SAT_W-1:0] m);
    logic [SAT_W-1:0] lim;
    logic [OUT_W-1:0] v;
    logic             s;
    lim = neg ? (SAT_W'(1) << (OUT_W - 1)) : ((SAT_W'(1) << (OUT_W - 1)) - SAT_W'(1));
    s   = m > lim;
    v   = s ? lim[OUT_W-1:0] : m[OUT_W-1:0];
    v   = neg ? (~v + OUT_W'(1)) : v;
    return {s, v};
  endfunction

endpackage

// ----- sv/segment_surface_tension_force_top.sv -----
// segment_surface_tension_force_top: surface tension force on one 2D segment
// per item, fully pipelined; uses sstf_pkg and sstf_div_pipe
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | to block  | in_valid_i/in_stall_o | seg_in_t: positions, velocities
//  out     | from block| out_valid_o/out_stall_i| seg_out_t: forces, energy, flags
//  cfg     | to block  | cfg_valid_i/cfg_ready_o| index and data, always ready
//
// one item enters every cycle while the skid slot is empty; the pipe's depth
// is set by the square root (one root bit a stage) and
// the two divider rounds (one quotient bit a stage)
// reset clears the valid bits, the skid slot and the registers to sigma 1.0
// with both force paths enabled
// a stall from the output fills the skid slot and then freezes every stage;
// nothing is dropped or repeated
module segment_surface_tension_force_top #(
  parameter int FRAC_BITS = sstf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  sstf_pkg::seg_in_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sstf_pkg::seg_out_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sstf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sstf_pkg::SIG_W-1:0]       cfg_data_i
);
  import sstf_pkg::*;

  // ---------------- configuration registers
  logic [SIG_W-1:0] sigma_q;
  logic             expl_q;
  logic             impl_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIG_W'(1) << FRAC_BITS;
      expl_q  <= 1'b1;
      impl_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TENSION:  sigma_q <= cfg_data_i;
        CFG_EXPLICIT: expl_q  <= cfg_data_i[0];
        CFG_IMPLICIT: impl_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance, frozen only while the skid slot holds an item
  logic     skid_vld_q;
  seg_out_t skid_q;
  logic     adv;

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // ---------------- stage 1: differences, sign extended by one bit
  logic              s1_vld_q;
  logic [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_vx_q, s1_vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dx_q <= {in_data_i.pos_a_x[COORD_BITS-1], in_data_i.pos_a_x}
               - {in_data_i.pos_b_x[COORD_BITS-1], in_data_i.pos_b_x};
      s1_dy_q <= {in_data_i.pos_a_y[COORD_BITS-1], in_data_i.pos_a_y}
               - {in_data_i.pos_b_y[COORD_BITS-1], in_data_i.pos_b_y};
      s1_vx_q <= {in_data_i.vel_a_x[COORD_BITS-1], in_data_i.vel_a_x}
               - {in_data_i.vel_b_x[COORD_BITS-1], in_data_i.vel_b_x};
      s1_vy_q <= {in_data_i.vel_a_y[COORD_BITS-1], in_data_i.vel_a_y}
               - {in_data_i.vel_b_y[COORD_BITS-1], in_data_i.vel_b_y};
    end
  end

  // ---------------- stage 2: magnitudes and signs
  logic              s2_vld_q;
  logic [DIFF_W-1:0] s2_adx_q, s2_ady_q, s2_avx_q, s2_avy_q;
  logic              s2_dxn_q, s2_dyn_q, s2_dyp_q, s2_n1_q, s2_n2_q;
  logic              dx_neg, dy_neg, dy_pos, vx_neg, vy_neg;

  assign dx_neg = s1_dx_q[DIFF_W-1];
  assign dy_neg = s1_dy_q[DIFF_W-1];
  assign dy_pos = !dy_neg && (s1_dy_q != '0);
  assign vx_neg = s1_vx_q[DIFF_W-1];
  assign vy_neg = s1_vy_q[DIFF_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_adx_q <= dx_neg ? (~s1_dx_q + DIFF_W'(1)) : s1_dx_q;
      s2_ady_q <= dy_neg ? (~s1_dy_q + DIFF_W'(1)) : s1_dy_q;
      s2_avx_q <= vx_neg ? (~s1_vx_q + DIFF_W'(1)) : s1_vx_q;
      s2_avy_q <= vy_neg ? (~s1_vy_q + DIFF_W'(1)) : s1_vy_q;
      s2_dxn_q <= dx_neg;
      s2_dyn_q <= dy_neg;
      s2_dyp_q <= dy_pos;
      // signs of vx*(-dy) and vy*dx
      s2_n1_q  <= vx_neg != dy_pos;
      s2_n2_q  <= vy_neg != dx_neg;
    end
  end

  // ---------------- stage 3: squares and cross products
  logic              s3_vld_q;
  logic [SQ_W-1:0]   s3_sqx_q, s3_sqy_q, s3_m1_q, s3_m2_q;
  logic [DIFF_W-1:0] s3_adx_q, s3_ady_q;
  logic              s3_dxn_q, s3_dyn_q, s3_dyp_q, s3_n1_q, s3_n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sqx_q <= s2_adx_q * s2_adx_q;
      s3_sqy_q <= s2_ady_q * s2_ady_q;
      s3_m1_q  <= s2_avx_q * s2_ady_q;
      s3_m2_q  <= s2_avy_q * s2_adx_q;
      s3_adx_q <= s2_adx_q;
      s3_ady_q <= s2_ady_q;
      s3_dxn_q <= s2_dxn_q;
      s3_dyn_q <= s2_dyn_q;
      s3_dyp_q <= s2_dyp_q;
      s3_n1_q  <= s2_n1_q;
      s3_n2_q  <= s2_n2_q;
    end
  end

  // ---------------- square root entry: radicand and signed cross sum
  logic [SQ_W-1:0] radicand;
  sq_side_t        rt_side_d;

  always_comb begin
    radicand          = s3_sqx_q + s3_sqy_q;
    rt_side_d.adx     = s3_adx_q;
    rt_side_d.ady     = s3_ady_q;
    rt_side_d.dxneg   = s3_dxn_q;
    rt_side_d.dyneg   = s3_dyn_q;
    rt_side_d.dypos   = s3_dyp_q;
    if (s3_n1_q == s3_n2_q) begin
      rt_side_d.wm   = s3_m1_q + s3_m2_q;
      rt_side_d.wneg = s3_n1_q;
    end else if (s3_m1_q >= s3_m2_q) begin
      rt_side_d.wm   = s3_m1_q - s3_m2_q;
      rt_side_d.wneg = s3_n1_q;
    end else begin
      rt_side_d.wm   = s3_m2_q - s3_m1_q;
      rt_side_d.wneg = s3_n2_q;
    end
  end

  // ---------------- square root: one root bit a stage
  logic                 rt_vld_q  [LEN_W+1];
  logic [LEN_W-1:0]     rt_root_q [LEN_W+1];
  sq_side_t             rt_side_q [LEN_W+1];
  logic [LEN_W-1:0]     rt_rem_q  [LEN_W];
  logic [2*LEN_W-1:0]   rt_rad_q  [LEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q[0] <= 1'b0;
    end else if (adv) begin
      rt_vld_q[0] <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_root_q[0] <= '0;
      rt_rem_q[0]  <= '0;
      rt_rad_q[0]  <= (2*LEN_W)'(radicand);
      rt_side_q[0] <= rt_side_d;
    end
  end

  for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
    logic [LEN_W+1:0] t;
    logic [LEN_W+1:0] trial;
    logic             ge;

    assign t     = {rt_rem_q[k], rt_rad_q[k][2*LEN_W-1 -: 2]};
    assign trial = {rt_root_q[k], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_root_q[k+1] <= {rt_root_q[k][LEN_W-2:0], ge};
        rt_side_q[k+1] <= rt_side_q[k];
      end
    end

    if (k < LEN_W - 1) begin : g_carry
      // remainder stays below 2*root, so it fits until the last bit
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rt_rem_q[k+1] <= ge ? LEN_W'(t - trial) : LEN_W'(t);
          rt_rad_q[k+1] <= {rt_rad_q[k][2*LEN_W-3:0], 2'b00};
        end
      end
    end
  end

  // ---------------- stage 5: products with sigma
  logic                    s5_vld_q;
  logic [DIFF_W+SIG_W-1:0] s5_px_q, s5_py_q;
  logic [SIG_W+LEN_W-1:0]  s5_pe_q;
  logic [LEN_W-1:0]        s5_len_q;
  sq_side_t                s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= rt_vld_q[LEN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_px_q   <= rt_side_q[LEN_W].adx * sigma_q;
      s5_py_q   <= rt_side_q[LEN_W].ady * sigma_q;
      s5_pe_q   <= sigma_q * rt_root_q[LEN_W];
      s5_len_q  <= rt_root_q[LEN_W];
      s5_side_q <= rt_side_q[LEN_W];
    end
  end

  // ---------------- first divider round: tension, normal, cross term, stiffness
  logic [LANES1-1:0][N1_W-1:0] d1_num;
  logic [LANES1-1:0][Q1_W-1:0] d1_quo;
  logic [N1_W-1:0]             stiff_num;
  logic [SIG_W+LEN_W-1:0]      eshift;
  side1_t                      d1_side_in, d1_side_out;
  logic                        d1_vld;

  always_comb begin
    stiff_num          = N1_W'(sigma_q) << FRAC_BITS;
    eshift             = s5_pe_q >> FRAC_BITS;
    d1_side_in.len     = s5_len_q;
    d1_side_in.dxneg   = s5_side_q.dxneg;
    d1_side_in.dyneg   = s5_side_q.dyneg;
    d1_side_in.dypos   = s5_side_q.dypos;
    d1_side_in.wneg    = s5_side_q.wneg;
    // stiffness quotient beyond the lane width saturates anyway
    d1_side_in.ovs     = stiff_num >= (N1_W'(s5_len_q) << Q1_W);
    d1_side_in.esat    = |eshift[SIG_W+LEN_W-1:OUT_W];
    d1_side_in.energy  = eshift[OUT_W-1:0];
    d1_num[LN_TX]      = N1_W'(s5_px_q);
    d1_num[LN_TY]      = N1_W'(s5_py_q);
    d1_num[LN_NX]      = N1_W'(s5_side_q.ady) << NORM_FRAC;
    d1_num[LN_NY]      = N1_W'(s5_side_q.adx) << NORM_FRAC;
    d1_num[LN_SM]      = N1_W'(s5_side_q.wm);
    d1_num[LN_ST]      = d1_side_in.ovs ? '0 : stiff_num;
  end

  sstf_div_pipe #(
    .DW    (LEN_W),
    .QW    (Q1_W),
    .LANES (LANES1),
    .SW    ($bits(side1_t))
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s5_vld_q),
    .den_i   (s5_len_q),
    .num_i   (d1_num),
    .side_i  (d1_side_in),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side_out)
  );

  // ---------------- stage 6: cross term times sigma
  logic              s6_vld_q;
  logic [PROD_W-1:0] s6_prod_q;
  logic [LEN_W-1:0]  s6_len_q;
  side2_t            s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s6_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_prod_q        <= d1_quo[LN_SM] * sigma_q;
      s6_len_q         <= d1_side_out.len;
      s6_side_q.tx     <= d1_quo[LN_TX][DIFF_W-1:0];
      s6_side_q.ty     <= d1_quo[LN_TY][DIFF_W-1:0];
      s6_side_q.nx     <= d1_quo[LN_NX][NRM_W-1:0];
      s6_side_q.ny     <= d1_quo[LN_NY][NRM_W-1:0];
      s6_side_q.st     <= d1_quo[LN_ST];
      s6_side_q.zero   <= d1_side_out.len == '0;
      s6_side_q.dxneg  <= d1_side_out.dxneg;
      s6_side_q.dyneg  <= d1_side_out.dyneg;
      s6_side_q.dypos  <= d1_side_out.dypos;
      s6_side_q.wneg   <= d1_side_out.wneg;
      s6_side_q.ovs    <= d1_side_out.ovs;
      s6_side_q.ovp    <= 1'b0;
      s6_side_q.esat   <= d1_side_out.esat;
      s6_side_q.energy <= d1_side_out.energy;
    end
  end

  // ---------------- second divider round: projected force magnitude
  logic [0:0][N2_W-1:0] d2_num;
  logic [0:0][Q2_W-1:0] d2_quo;
  side2_t               d2_side_in, d2_side_out;
  logic                 d2_vld;

  always_comb begin
    d2_side_in     = s6_side_q;
    // quotient too wide for the lane is clamped like any large one
    d2_side_in.ovp = N2_W'(s6_prod_q) >= (N2_W'(s6_len_q) << Q2_W);
    d2_num[0]      = d2_side_in.ovp ? '0 : N2_W'(s6_prod_q);
  end

  sstf_div_pipe #(
    .DW    (LEN_W),
    .QW    (Q2_W),
    .LANES (1),
    .SW    ($bits(side2_t))
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s6_vld_q),
    .den_i   (s6_len_q),
    .num_i   (d2_num),
    .side_i  (d2_side_in),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side_out)
  );

  // ---------------- stage 7: clamp
  logic            s7_vld_q;
  logic [Q2_W-1:0] s7_pm_q;
  side2_t          s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (adv) begin
      s7_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_pm_q   <= (d2_side_out.ovp || d2_quo[0] > P_CLAMP) ? P_CLAMP : d2_quo[0];
      s7_side_q <= d2_side_out;
    end
  end

  // ---------------- stage 8: split products with the normal
  logic                   s8_vld_q;
  logic [PHI_W+NRM_W-1:0] s8_phx_q, s8_phy_q;
  logic [PLO_W+NRM_W-1:0] s8_plx_q, s8_ply_q;
  side2_t                 s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (adv) begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_phx_q  <= s7_pm_q[Q2_W-1:PLO_W] * s7_side_q.nx;
      s8_plx_q  <= s7_pm_q[PLO_W-1:0] * s7_side_q.nx;
      s8_phy_q  <= s7_pm_q[Q2_W-1:PLO_W] * s7_side_q.ny;
      s8_ply_q  <= s7_pm_q[PLO_W-1:0] * s7_side_q.ny;
      s8_side_q <= s7_side_q;
    end
  end

  // ---------------- stage 9: recombine and drop the normal's fraction
  logic             s9_vld_q;
  logic [SAT_W-1:0] s9_tdx_q, s9_tdy_q;
  side2_t           s9_side_q;
  logic [SUM_W-1:0] sum_x, sum_y;

  assign sum_x = {1'b0, s8_phx_q, {PLO_W{1'b0}}} + SUM_W'(s8_plx_q);
  assign sum_y = {1'b0, s8_phy_q, {PLO_W{1'b0}}} + SUM_W'(s8_ply_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (adv) begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_tdx_q  <= sum_x[SUM_W-1:NORM_FRAC];
      s9_tdy_q  <= sum_y[SUM_W-1:NORM_FRAC];
      s9_side_q <= s8_side_q;
    end
  end

  // ---------------- stage 10: saturation, enables, zero length
  logic     p_vld_q;
  seg_out_t p_q;
  seg_out_t res_d;
  logic     [OUT_W:0] sx, sy, sdx, sdy;

  assign sx  = sat_s32(s9_side_q.dxneg, SAT_W'(s9_side_q.tx));
  assign sy  = sat_s32(s9_side_q.dyneg, SAT_W'(s9_side_q.ty));
  assign sdx = sat_s32(s9_side_q.wneg != s9_side_q.dypos, s9_tdx_q);
  assign sdy = sat_s32(s9_side_q.wneg != s9_side_q.dxneg, s9_tdy_q);

  always_comb begin
    res_d = '0;
    if (s9_side_q.zero) begin
      res_d.degenerate = 1'b1;
    end else begin
      if (expl_q) begin
        res_d.tension_x   = sx[OUT_W-1:0];
        res_d.tension_y   = sy[OUT_W-1:0];
        res_d.energy_term = s9_side_q.esat ? '1 : s9_side_q.energy;
        res_d.saturated   = sx[OUT_W] | sy[OUT_W] | s9_side_q.esat;
      end
      if (impl_q) begin
        res_d.damping_x = sdx[OUT_W-1:0];
        res_d.damping_y = sdy[OUT_W-1:0];
        res_d.saturated = res_d.saturated | sdx[OUT_W] | sdy[OUT_W];
      end
      // stiffness is never disabled
      if (s9_side_q.ovs || (|s9_side_q.st[Q1_W-1:OUT_W])) begin
        res_d.stiffness = '1;
        res_d.saturated = 1'b1;
      end else begin
        res_d.stiffness = s9_side_q.st[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q <= res_d;
    end
  end

  // ---------------- skid slot: parks a stalled item so the pipe can move once more
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      skid_vld_q <= p_vld_q && out_stall_i;
    end else if (!out_stall_i) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      skid_q <= p_q;
    end
  end

  assign out_valid_o = skid_vld_q | p_vld_q;
  assign out_data_o  = skid_vld_q ? skid_q : p_q;

  // ---------------- assertions
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_stall_i |=> !skid_vld_q)
    else $error("skid slot kept an item that was taken");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(p_vld_q) && $stable(s9_vld_q))
    else $error("pipeline moved while the skid slot was full");

  a_take_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_vld_q)
    else $error("accepted item did not enter the first stage");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.tension_x == '0 && out_data_o.damping_x == '0 &&
      out_data_o.tension_y == '0 && out_data_o.damping_y == '0 &&
      !out_data_o.saturated)
    else $error("zero length segment gave a nonzero force");

endmodule

// ----- sv/sstf_div_pipe.sv -----
// sstf_div_pipe: pipelined restoring divider, one quotient bit per stage,
// several numerators over one shared divisor, sideband carried along
// depends on nothing outside this file
module sstf_div_pipe #(
  parameter int DW    = 34,
  parameter int QW    = 36,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [DW-1:0]                  den_i,
  input  logic [LANES-1:0][DW+QW-1:0]    num_i,
  input  logic [SW-1:0]                  side_i,
  output logic                           valid_o,
  output logic [LANES-1:0][QW-1:0]       quo_o,
  output logic [SW-1:0]                  side_o
);

  // numerator must be below den << QW
  logic                       vld_q  [QW+1];
  logic [LANES-1:0][QW-1:0]   quo_q  [QW+1];
  logic [SW-1:0]              side_q [QW+1];
  logic [DW-1:0]              den_q  [QW];
  logic [LANES-1:0][DW-1:0]   rem_q  [QW];
  logic [LANES-1:0][QW-1:0]   low_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= num_i[l][DW+QW-1:QW];
        low_q[0][l] <= num_i[l][QW-1:0];
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LANES-1:0][DW:0] trial;
    logic [LANES-1:0]       ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_q[k][l], low_q[k][l][QW-1]};
        ge[l]    = trial[l] >= {1'b0, den_q[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        for (int l = 0; l < LANES; l++) begin
          quo_q[k+1][l] <= {quo_q[k][l][QW-2:0], ge[l]};
        end
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k+1] <= den_q[k];
          for (int l = 0; l < LANES; l++) begin
            rem_q[k+1][l] <= ge[l] ? DW'(trial[l] - {1'b0, den_q[k]}) : trial[l][DW-1:0];
            low_q[k+1][l] <= {low_q[k][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ----- tb/segment_surface_tension_force_top_tb.sv -----
// segment_surface_tension_force_top_tb: self-checking bench for the segment surface
// tension force block; random segments, random gaps and stalls, config phases
// depends on sstf_pkg and segment_surface_tension_force_top
`timescale 1ns / 100ps

module segment_surface_tension_force_top_tb;
  import sstf_pkg::*;

  localparam int LATENCY = 145;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  seg_in_t in_data;
  logic out_valid;
  logic out_stall;
  seg_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIG_W-1:0] cfg_data;

  // predictor copy of the registers
  logic [31:0] sigma_q;
  logic        expl_en_q;
  logic        impl_en_q;

  seg_in_t  segment_queue[$];
  seg_out_t force_queue[$];
  int       mismatch_count;
  bit       driver_hold;
  int       burst_left;
  int       gap_left;
  int       stall_mode;
  // input item taken at the last rising edge
  logic     in_taken;

  segment_surface_tension_force_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // saturate sign and magnitude to a signed 32 bit value
  function automatic logic [31:0] clip_signed(input logic neg, input logic [191:0] m,
                                              inout logic sat);
    logic [191:0] lim;
    logic [31:0]  v;
    lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
    v = m[31:0];
    if (m > lim) begin
      v = lim[31:0];
      sat = 1'b1;
    end
    return neg ? (~v + 32'd1) : v;
  endfunction

  // integer floor square root of a wide value
  function automatic logic [63:0] floor_root(input logic [191:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (192'(c) * 192'(c) <= s) r = c;
    end
    return r;
  endfunction

  // expected result of one segment under the current registers
  function automatic seg_out_t segment_force(input seg_in_t s);
    seg_out_t     r;
    logic signed [63:0] dx, dy, vx, vy;
    logic [63:0]  adx, ady, len;
    logic [191:0] sg, q, m1, m2, wm, pm, nxm, nym, st;
    logic         sat, n1, n2, wneg;
    r = '0;
    sat = 1'b0;
    dx = 64'(s.pos_a_x) - 64'(s.pos_b_x);
    dy = 64'(s.pos_a_y) - 64'(s.pos_b_y);
    vx = 64'(s.vel_a_x) - 64'(s.vel_b_x);
    vy = 64'(s.vel_a_y) - 64'(s.vel_b_y);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sg = 192'(sigma_q);
    len = floor_root(192'(adx) * 192'(adx) + 192'(ady) * 192'(ady));
    if (len == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    if (expl_en_q) begin
      r.tension_x = clip_signed(dx < 0, (192'(adx) * sg) / 192'(len), sat);
      r.tension_y = clip_signed(dy < 0, (192'(ady) * sg) / 192'(len), sat);
      q = (sg * 192'(len)) >> FRAC_BITS_DEF;
      if (q > 192'hFFFF_FFFF) begin
        r.energy_term = '1;
        sat = 1'b1;
      end else begin
        r.energy_term = q[31:0];
      end
    end
    if (impl_en_q) begin
      n1 = (vx < 0) != (dy > 0);
      n2 = (vy < 0) != (dx < 0);
      m1 = 192'(vx < 0 ? -vx : vx) * 192'(ady);
      m2 = 192'(vy < 0 ? -vy : vy) * 192'(adx);
      if (n1 == n2) begin
        wm = m1 + m2;
        wneg = n1;
      end else if (m1 >= m2) begin
        wm = m1 - m2;
        wneg = n1;
      end else begin
        wm = m2 - m1;
        wneg = n2;
      end
      q = wm / 192'(len);
      pm = (192'(q[63:0]) * sg) / 192'(len);
      if (pm > (192'd1 << 62)) pm = 192'd1 << 62;
      nxm = (192'(ady) << NORM_FRAC) / 192'(len);
      nym = (192'(adx) << NORM_FRAC) / 192'(len);
      r.damping_x = clip_signed(wneg != (dy > 0),
                                (192'(pm[63:0]) * 192'(nxm[63:0])) >> NORM_FRAC, sat);
      r.damping_y = clip_signed(wneg != (dx < 0),
                                (192'(pm[63:0]) * 192'(nym[63:0])) >> NORM_FRAC, sat);
    end
    st = (sg << FRAC_BITS_DEF) / 192'(len);
    if (st > 192'hFFFF_FFFF) begin
      st = 192'hFFFF_FFFF;
      sat = 1'b1;
    end
    r.stiffness = st[31:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  // note whether the offered item was taken at the rising edge
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
    end
  end

  // driver: bursts of items with random gaps, fed from the pending queue
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      // previous item was taken (or none was offered)
      if (in_valid && in_taken) force_queue.push_back(segment_force(in_data));
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (driver_hold || segment_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= segment_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern: runs of stalls and runs of free flow
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    seg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (force_queue.size() == 0) begin
        report_mismatch("unexpected result item", 32'd0, 32'd0);
      end else begin
        want = force_queue.pop_front();
        if (out_data.tension_x !== want.tension_x)
          report_mismatch("tension_x", out_data.tension_x, want.tension_x);
        if (out_data.tension_y !== want.tension_y)
          report_mismatch("tension_y", out_data.tension_y, want.tension_y);
        if (out_data.damping_x !== want.damping_x)
          report_mismatch("damping_x", out_data.damping_x, want.damping_x);
        if (out_data.damping_y !== want.damping_y)
          report_mismatch("damping_y", out_data.damping_y, want.damping_y);
        if (out_data.energy_term !== want.energy_term)
          report_mismatch("energy_term", out_data.energy_term, want.energy_term);
        if (out_data.stiffness !== want.stiffness)
          report_mismatch("stiffness", out_data.stiffness, want.stiffness);
        if (out_data.degenerate !== want.degenerate)
          report_mismatch("degenerate", 32'(out_data.degenerate), 32'(want.degenerate));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
  end

  // random coordinate: mostly moderate, sometimes extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  function automatic seg_in_t rand_segment();
    seg_in_t s;
    s.pos_a_x = rand_coord();
    s.pos_a_y = rand_coord();
    s.pos_b_x = rand_coord();
    s.pos_b_y = rand_coord();
    s.vel_a_x = rand_coord();
    s.vel_a_y = rand_coord();
    s.vel_b_x = rand_coord();
    s.vel_b_y = rand_coord();
    // an occasional zero length segment
    if ($urandom_range(0, 30) == 0) begin
      s.pos_b_x = s.pos_a_x;
      s.pos_b_y = s.pos_a_y;
    end
    return s;
  endfunction

  function automatic seg_in_t make_segment(input logic [31:0] ax, ay, bx, by,
                                           vax, vay, vbx, vby);
    seg_in_t s;
    s = '{ax, ay, bx, by, vax, vay, vbx, vby};
    return s;
  endfunction

  // wait until every expected result has come, then let the pipe drain
  task automatic wait_drained();
    while (segment_queue.size() != 0 || in_valid || force_queue.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // write one register at the falling edge, done when ready is seen
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TENSION:  sigma_q = val;
      CFG_EXPLICIT: expl_en_q = val[0];
      CFG_IMPLICIT: impl_en_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] sigmas[5];
    mismatch_count = 0;
    driver_hold = 1'b0;
    sigma_q = 32'd65536;
    expl_en_q = 1'b1;
    impl_en_q = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_TENSION;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, degenerate, axis aligned, tiny lengths
    segment_queue.push_back(make_segment(0, 0, 0, 0, 1, 2, 3, 4));
    segment_queue.push_back(make_segment(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0));
    segment_queue.push_back(make_segment(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0));
    segment_queue.push_back(make_segment(1, 0, 0, 0, 0, 1, 0, 0));
    segment_queue.push_back(make_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                         32'h8000_0000, 32'h7FFF_FFFF));
    segment_queue.push_back(make_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF));
    segment_queue.push_back(make_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                                         32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    segment_queue.push_back(make_segment(32'h0003_0000, 32'h0004_0000, 0, 0,
                                         32'h0010_0000, 32'hFFF0_0000, 0, 0));
    segment_queue.push_back(make_segment(32'h8000_0000, 0, 32'h8000_0000, 0, 5, 5, 5, 5));
    segment_queue.push_back(make_segment(0, 1, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0,
                                         32'h7FFF_FFFF, 0));
    wait_drained();

    // phases over the register space, extremes included
    sigmas = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, 32'h0000_8000};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_TENSION, (ph < 5) ? sigmas[ph] : $urandom());
      write_reg(CFG_EXPLICIT, (ph % 3 == 1) ? 32'd0 : 32'hFFFF_FFFF);
      write_reg(CFG_IMPLICIT, (ph % 4 == 2) ? 32'hFFFF_FFFE : 32'd1);
      for (int k = 0; k < 84; k++) segment_queue.push_back(rand_segment());
      // one phase holds the sender until the pipe has emptied mid way
      if (ph == 4) begin
        while (segment_queue.size() > 40) @(posedge clk);
        driver_hold = 1'b1;
        while (in_valid || force_queue.size() != 0) @(posedge clk);
        @(negedge clk);
        driver_hold = 1'b0;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("segment_surface_tension_force_top_tb: PASS");
    end else begin
      $display("segment_surface_tension_force_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("segment_surface_tension_force_top_tb: FAIL");
    $finish;
  end

endmodule
